// ----- hw/rtl/tost_pkg.sv -----
// shared types and constants for the tick ordered snapshot table
`default_nettype none
package tost_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam logic [6:0]  MAX_ENTRIES_RST     = 7'd64;
	localparam logic [31:0] MAX_TOTAL_BYTES_RST = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		OP_STORE = 2'd0,
		OP_FIND  = 2'd1,
		OP_PRUNE = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_MAX_ENTRIES     = 2'd0,
		REG_MAX_TOTAL_BYTES = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] tick;
		logic [31:0] size;
		logic [31:0] capt;
	} entry_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tost_if.sv -----
// handshake channels: request items, result items and register writes
`default_nettype none
interface tost_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] entry_tick;
	logic [31:0] snapshot_bytes;
	logic [31:0] captured_tick;
	modport source (output valid, operation, entry_tick, snapshot_bytes, captured_tick,
		input ready);
	modport sink (input valid, operation, entry_tick, snapshot_bytes, captured_tick,
		output ready);
endinterface

interface tost_rsp_if;
	logic        valid;
	logic        ready;
	logic        store_rejected;
	logic        found;
	logic [31:0] found_tick;
	logic [31:0] found_bytes;
	logic [31:0] found_captured;
	logic [6:0]  entry_count;
	logic [31:0] total_bytes;
	logic        latest_valid;
	logic [31:0] latest_tick;
	modport source (output valid, store_rejected, found, found_tick, found_bytes,
		found_captured, entry_count, total_bytes, latest_valid, latest_tick, input ready);
	modport sink (input valid, store_rejected, found, found_tick, found_bytes,
		found_captured, entry_count, total_bytes, latest_valid, latest_tick, output ready);
endinterface

interface tost_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tost_ring.sv -----
// ring memory of descriptors addressed by position relative to the oldest entry
`default_nettype none
module tost_ring #(
	parameter int CAPACITY = tost_pkg::CAPACITY_DEF,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  wire                           clk,
	input  wire  [AW-1:0]                 head,
	input  wire  [CW-1:0]                 rd_idx,
	output tost_pkg::entry_t              rd_data,
	input  wire                           we,
	input  wire  [CW-1:0]                 wr_idx,
	input  tost_pkg::entry_t              wr_data
);
	localparam logic [CW:0] CAP_W = (CW + 1)'(CAPACITY);

	tost_pkg::entry_t mem [CAPACITY];

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
		logic [CW:0] s;
		s = {{(CW + 1 - AW){1'b0}}, h} + {1'b0, i};
		if (s >= CAP_W) begin
			s = s - CAP_W;
		end
		return s[AW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (we) begin
			mem[phys(head, wr_idx)] <= wr_data;
		end
		rd_data <= mem[phys(head, rd_idx)];
	end

endmodule
`default_nettype wire

// ----- hw/rtl/tick_ordered_snapshot_table.sv -----
// top level: sorted snapshot descriptor table with a ring memory and a sequencer
// clear and a refused store skip the scan and go straight to the result; a store may be
// followed by trim evictions of the oldest entries; the scan and the insert shift walk the
// ring memory one entry a cycle through its single read and single write port; one item at
// a time, the result register lets the next item start while it waits; reset empties the
// table and loads the register defaults
`default_nettype none
module tick_ordered_snapshot_table #(
	parameter int CAPACITY = tost_pkg::CAPACITY_DEF
) (
	input wire          clk,
	input wire          arst_n,
	tost_req_if.sink    req,
	tost_rsp_if.source  rsp,
	tost_cfg_if.sink    cfg
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = (CW > 7) ? CW : 7;
	localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
	localparam logic [AW:0]   CAP_A  = (AW + 1)'(CAPACITY);
	localparam logic [CW-1:0] ONE_C  = CW'(1);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_SCAN    = 8'b0000_0010,
		S_SHIFT   = 8'b0000_0100,
		S_INS     = 8'b0000_1000,
		S_TRIM_RD = 8'b0001_0000,
		S_TRIM_EV = 8'b0010_0000,
		S_FIN     = 8'b0100_0000
	} state_t;

	state_t state_q;

	tost_pkg::op_t    op_q;
	logic [31:0]      tick_q, bytes_q, capt_q;
	logic [CW-1:0]    count_q, scan_idx_q, idx_s1, pos_q, rem_q, r_q;
	logic [AW-1:0]    head_q;
	logic [32:0]      total_q;
	logic [31:0]      latest_q, front_size_q;
	logic [6:0]       maxent_q;
	logic [31:0]      maxbytes_q;
	logic             pend_s1, found_q, rej_q;
	tost_pkg::entry_t fnd_q;

	logic [CW-1:0]    rd_idx, wr_idx;
	logic             we;
	tost_pkg::entry_t rd_data, wr_data;

	tost_ring #(.CAPACITY(CAPACITY)) u_ring (
		.clk     (clk),
		.head    (head_q),
		.rd_idx  (rd_idx),
		.rd_data (rd_data),
		.we      (we),
		.wr_idx  (wr_idx),
		.wr_data (wr_data)
	);

	function automatic logic [AW-1:0] head_add(input logic [AW-1:0] h, input logic [CW-1:0] k);
		logic [AW:0] s;
		s = {1'b0, h} + (AW + 1)'(k);
		if (s >= CAP_A) begin
			s = s - CAP_A;
		end
		return s[AW-1:0];
	endfunction

	logic scan_cont, scan_stop, over_lim, trim_ev;

	always_comb begin
		if (op_q == tost_pkg::OP_FIND) begin
			scan_cont = rd_data.tick <= tick_q;
		end else begin
			scan_cont = rd_data.tick < tick_q;
		end
		scan_stop = pend_s1 && ((idx_s1 == count_q) || !scan_cont);
		over_lim  = WW'(count_q) > WW'(maxent_q);
		trim_ev   = (count_q != '0) && (over_lim || (total_q > {1'b0, maxbytes_q}));
	end

	always_comb begin
		unique case (state_q)
			S_SCAN:    rd_idx = scan_idx_q;
			S_SHIFT:   rd_idx = r_q;
			S_TRIM_EV: rd_idx = ONE_C;
			default:   rd_idx = '0;
		endcase
		we      = 1'b0;
		wr_idx  = idx_s1 + ONE_C;
		wr_data = rd_data;
		if (state_q == S_SHIFT && pend_s1) begin
			we = 1'b1;
		end else if (state_q == S_INS) begin
			we      = 1'b1;
			wr_idx  = pos_q;
			wr_data = '{tick: tick_q, size: bytes_q, capt: capt_q};
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxent_q   <= tost_pkg::MAX_ENTRIES_RST;
			maxbytes_q <= tost_pkg::MAX_TOTAL_BYTES_RST;
		end else if (cfg.valid) begin
			if (cfg.index == tost_pkg::REG_MAX_ENTRIES) begin
				maxent_q <= cfg.data[6:0];
			end else if (cfg.index == tost_pkg::REG_MAX_TOTAL_BYTES) begin
				maxbytes_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			head_q    <= '0;
			total_q   <= '0;
			pend_s1   <= 1'b0;
			rsp.valid <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready && state_q != S_FIN) begin
				rsp.valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q       <= tost_pkg::op_t'(req.operation);
						tick_q     <= req.entry_tick;
						bytes_q    <= req.snapshot_bytes;
						capt_q     <= req.captured_tick;
						found_q    <= 1'b0;
						fnd_q      <= '0;
						rej_q      <= 1'b0;
						scan_idx_q <= '0;
						pend_s1    <= 1'b0;
						if (req.operation == tost_pkg::OP_CLEAR) begin
							count_q <= '0;
							total_q <= '0;
							state_q <= S_FIN;
						end else if (req.operation == tost_pkg::OP_STORE &&
							req.snapshot_bytes > maxbytes_q) begin
							rej_q   <= 1'b1;
							state_q <= S_FIN;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// read one ahead while comparing the entry read last cycle
					pend_s1 <= !scan_stop;
					idx_s1  <= scan_idx_q;
					if (scan_idx_q != count_q) begin
						scan_idx_q <= scan_idx_q + ONE_C;
					end
					if (scan_stop) begin
						unique case (op_q)
							tost_pkg::OP_FIND: begin
								state_q <= S_FIN;
							end
							tost_pkg::OP_PRUNE: begin
								head_q  <= head_add(head_q, idx_s1);
								count_q <= count_q - idx_s1;
								state_q <= S_FIN;
							end
							default: begin
								rem_q <= count_q - idx_s1;
								if (count_q == CAP_C && idx_s1 == '0) begin
									// new entry would be the oldest of a full table
									state_q <= S_TRIM_RD;
								end else if (count_q == CAP_C) begin
									total_q <= total_q + {1'b0, bytes_q} - {1'b0, front_size_q};
									head_q  <= head_add(head_q, ONE_C);
									count_q <= count_q - ONE_C;
									pos_q   <= idx_s1 - ONE_C;
									r_q     <= (count_q == idx_s1) ? '0 : count_q - CW'(2);
									state_q <= S_SHIFT;
								end else begin
									total_q <= total_q + {1'b0, bytes_q};
									pos_q   <= idx_s1;
									r_q     <= (count_q == idx_s1) ? '0 : count_q - ONE_C;
									state_q <= S_SHIFT;
								end
							end
						endcase
					end else if (pend_s1) begin
						if (idx_s1 == '0) begin
							front_size_q <= rd_data.size;
						end
						if (op_q == tost_pkg::OP_FIND) begin
							found_q <= 1'b1;
							fnd_q   <= rd_data;
						end else if (op_q == tost_pkg::OP_PRUNE) begin
							total_q <= total_q - {1'b0, rd_data.size};
						end
					end
				end
				S_SHIFT: begin
					// move entries up one slot, newest first
					if (rem_q != '0) begin
						pend_s1 <= 1'b1;
						idx_s1  <= r_q;
						rem_q   <= rem_q - ONE_C;
						if (rem_q != ONE_C) begin
							r_q <= r_q - ONE_C;
						end
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							state_q <= S_INS;
						end
					end
				end
				S_INS: begin
					count_q <= count_q + ONE_C;
					if (pos_q == count_q) begin
						latest_q <= tick_q;
					end
					state_q <= S_TRIM_RD;
				end
				S_TRIM_RD: begin
					state_q <= S_TRIM_EV;
				end
				S_TRIM_EV: begin
					if (trim_ev) begin
						total_q <= total_q - {1'b0, rd_data.size};
						head_q  <= head_add(head_q, ONE_C);
						count_q <= count_q - ONE_C;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!rsp.valid || rsp.ready) begin
						rsp.valid          <= 1'b1;
						rsp.store_rejected <= rej_q;
						rsp.found          <= found_q;
						rsp.found_tick     <= fnd_q.tick;
						rsp.found_bytes    <= fnd_q.size;
						rsp.found_captured <= fnd_q.capt;
						rsp.entry_count    <= 7'(WW'(count_q));
						rsp.total_bytes    <= total_q[31:0];
						rsp.latest_valid   <= (count_q != '0);
						rsp.latest_tick    <= (count_q != '0) ? latest_q : 32'd0;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C) else $error("entry count above capacity");
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, head_q} < CAP_A) else $error("head pointer out of range");
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS || state_q == S_SHIFT) |-> count_q < CAP_C)
		else $error("insert into a full table");
	a_fin_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && (!rsp.valid || rsp.ready)) |=> rsp.valid && state_q == S_IDLE)
		else $error("result not posted");

endmodule
`default_nettype wire

// ----- test/tost_checker.sv -----
// checker: predicts snapshot table results and compares them with the result channel
`default_nettype none
module tost_checker (
	input wire       clk,
	input wire       arst_n,
	tost_req_if.sink req_mon,
	tost_rsp_if.sink rsp_mon,
	tost_cfg_if.sink cfg_mon,
	output int       fail_count,
	output int       pending
);

	typedef struct packed {
		logic        store_rejected;
		logic        found;
		logic [31:0] found_tick;
		logic [31:0] found_bytes;
		logic [31:0] found_captured;
		logic [6:0]  entry_count;
		logic [31:0] total_bytes;
		logic        latest_valid;
		logic [31:0] latest_tick;
	} table_status_t;

	tost_pkg::entry_t shadow_tbl [tost_pkg::CAPACITY_DEF];
	int               shadow_cnt;
	logic [32:0]      shadow_bytes;
	logic [6:0]       lim_entries;
	logic [31:0]      lim_bytes;
	table_status_t    status_q [$];

	function automatic void drop_oldest();
		if (shadow_cnt == 0)
			return;
		shadow_bytes -= shadow_tbl[0].size;
		for (int i = 1; i < shadow_cnt; i++)
			shadow_tbl[i-1] = shadow_tbl[i];
		shadow_cnt--;
	endfunction

	function automatic void insert_sorted(tost_pkg::entry_t e);
		int pos;
		int lim;
		bit skip;
		pos = 0;
		skip = 0;
		while (pos < shadow_cnt && shadow_tbl[pos].tick < e.tick)
			pos++;
		shadow_bytes += e.size;
		if (shadow_cnt >= tost_pkg::CAPACITY_DEF) begin
			if (pos == 0) begin
				// new item sorts first in a full table: dropped at once
				shadow_bytes -= e.size;
				skip = 1;
			end else begin
				drop_oldest();
				pos--;
			end
		end
		if (!skip) begin
			for (int i = shadow_cnt; i > pos; i--)
				shadow_tbl[i] = shadow_tbl[i-1];
			shadow_tbl[pos] = e;
			shadow_cnt++;
		end
		lim = (lim_entries > tost_pkg::CAPACITY_DEF) ? tost_pkg::CAPACITY_DEF : lim_entries;
		while (shadow_cnt > 0 && (shadow_cnt > lim || shadow_bytes > {1'b0, lim_bytes}))
			drop_oldest();
	endfunction

	function automatic table_status_t table_apply(tost_pkg::op_t op, logic [31:0] tick,
		logic [31:0] bytes, logic [31:0] capt);
		table_status_t s;
		int k;
		s = '0;
		case (op)
			tost_pkg::OP_STORE: begin
				if (bytes > lim_bytes)
					s.store_rejected = 1;
				else
					insert_sorted('{tick: tick, size: bytes, capt: capt});
			end
			tost_pkg::OP_FIND: begin
				for (int i = 0; i < shadow_cnt && shadow_tbl[i].tick <= tick; i++) begin
					s.found = 1;
					s.found_tick = shadow_tbl[i].tick;
					s.found_bytes = shadow_tbl[i].size;
					s.found_captured = shadow_tbl[i].capt;
				end
			end
			tost_pkg::OP_PRUNE: begin
				k = 0;
				while (k < shadow_cnt && shadow_tbl[k].tick < tick) begin
					shadow_bytes -= shadow_tbl[k].size;
					k++;
				end
				for (int i = k; i < shadow_cnt; i++)
					shadow_tbl[i-k] = shadow_tbl[i];
				shadow_cnt -= k;
			end
			default: begin
				shadow_cnt = 0;
				shadow_bytes = '0;
			end
		endcase
		s.entry_count = shadow_cnt[6:0];
		s.total_bytes = shadow_bytes[31:0];
		s.latest_valid = shadow_cnt > 0;
		s.latest_tick = shadow_cnt > 0 ? shadow_tbl[shadow_cnt-1].tick : '0;
		return s;
	endfunction

	assign pending = status_q.size();

	always @(posedge clk or negedge arst_n) begin
		table_status_t got;
		table_status_t want;
		if (!arst_n) begin
			shadow_cnt = 0;
			shadow_bytes = '0;
			lim_entries <= tost_pkg::MAX_ENTRIES_RST;
			lim_bytes <= tost_pkg::MAX_TOTAL_BYTES_RST;
			fail_count <= 0;
			status_q.delete();
		end else begin
			if (cfg_mon.valid && cfg_mon.ready) begin
				if (cfg_mon.index == tost_pkg::REG_MAX_ENTRIES)
					lim_entries <= cfg_mon.data[6:0];
				else if (cfg_mon.index == tost_pkg::REG_MAX_TOTAL_BYTES)
					lim_bytes <= cfg_mon.data;
			end
			if (req_mon.valid && req_mon.ready)
				status_q.push_back(table_apply(tost_pkg::op_t'(req_mon.operation),
					req_mon.entry_tick, req_mon.snapshot_bytes, req_mon.captured_tick));
			if (rsp_mon.valid && rsp_mon.ready) begin
				got = '{rsp_mon.store_rejected, rsp_mon.found, rsp_mon.found_tick,
					rsp_mon.found_bytes, rsp_mon.found_captured, rsp_mon.entry_count,
					rsp_mon.total_bytes, rsp_mon.latest_valid, rsp_mon.latest_tick};
				if (status_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result item %p", got);
					fail_count <= fail_count + 1;
				end else begin
					want = status_q.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("mismatch: expected %p, got %p", want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- test/tick_ordered_snapshot_table_tb.sv -----
// testbench top: drives requests, register writes and result stalls, gives the verdict
`default_nettype none
module tick_ordered_snapshot_table_tb;

	logic clk = 0;
	logic arst_n = 0;
	int   cycle_count = 0;
	int   fail_count;
	int   pending;

	tost_req_if req ();
	tost_rsp_if rsp ();
	tost_cfg_if cfg ();

	tick_ordered_snapshot_table uut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg));
	tost_checker chk (.clk(clk), .arst_n(arst_n), .req_mon(req), .rsp_mon(rsp), .cfg_mon(cfg),
		.fail_count(fail_count), .pending(pending));

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
	end

	// result side sometimes stalls, at random, before taking an item
	initial begin
		int gap;
		rsp.ready = 0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
			if (gap != 0) begin
				rsp.ready <= 0;
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("tick_ordered_snapshot_table_tb: done, errors");
			$finish;
		end
	end

	task automatic write_reg(tost_pkg::reg_idx_t idx, logic [31:0] value);
		cfg.index <= idx;
		cfg.data <= value;
		cfg.valid <= 1;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 0;
		@(posedge clk);
	endtask

	task automatic send_op(tost_pkg::op_t op, logic [31:0] tick, logic [31:0] bytes,
		logic [31:0] capt);
		int gap;
		gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			req.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req.operation <= op;
		req.entry_tick <= tick;
		req.snapshot_bytes <= bytes;
		req.captured_tick <= capt;
		req.valid <= 1;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	// wait until every result is in, then let the block settle before a write
	task automatic drain();
		req.valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		return $urandom();
	endfunction

	task automatic random_phase(int n, int tick_span, bit big_sizes);
		int r;
		logic [31:0] sz;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			sz = big_sizes ? rand_word() : $urandom_range(0, 2000);
			if (r < 55)
				send_op(tost_pkg::OP_STORE, $urandom_range(0, tick_span), sz, rand_word());
			else if (r < 80)
				send_op(tost_pkg::OP_FIND, $urandom_range(0, tick_span + 5), '0, '0);
			else if (r < 93)
				send_op(tost_pkg::OP_PRUNE, $urandom_range(0, tick_span / 3), '0, '0);
			else if (r < 97)
				send_op(tost_pkg::OP_CLEAR, rand_word(), rand_word(), rand_word());
			else
				send_op(tost_pkg::op_t'($urandom_range(0, 3)), rand_word(), rand_word(),
					rand_word());
		end
	endtask

	initial begin
		req.valid = 0;
		req.operation = tost_pkg::OP_STORE;
		req.entry_tick = '0;
		req.snapshot_bytes = '0;
		req.captured_tick = '0;
		cfg.valid = 0;
		cfg.index = tost_pkg::REG_MAX_ENTRIES;
		cfg.data = '0;
		@(posedge arst_n);
		@(posedge clk);
		// directed: extremes, equal ticks, rejects, every operation
		send_op(tost_pkg::OP_FIND, 32'hFFFF_FFFF, '0, '0);
		send_op(tost_pkg::OP_STORE, 32'd10, 32'd100, 32'hFFFF_FFFF);
		send_op(tost_pkg::OP_STORE, 32'd10, 32'd200, 32'd1);
		send_op(tost_pkg::OP_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		send_op(tost_pkg::OP_STORE, 32'd0, 32'd0, 32'hA5A5_5A5A);
		send_op(tost_pkg::OP_FIND, 32'd9, '0, '0);
		send_op(tost_pkg::OP_FIND, 32'd10, '0, '0);
		send_op(tost_pkg::OP_FIND, 32'd0, '0, '0);
		send_op(tost_pkg::OP_PRUNE, 32'd10, '0, '0);
		send_op(tost_pkg::OP_PRUNE, 32'd0, '0, '0);
		send_op(tost_pkg::OP_CLEAR, '0, '0, '0);
		send_op(tost_pkg::OP_PRUNE, 32'hFFFF_FFFF, '0, '0);
		drain();
		write_reg(tost_pkg::REG_MAX_TOTAL_BYTES, 32'd1000);
		send_op(tost_pkg::OP_STORE, 32'd5, 32'd1001, 32'd1);
		send_op(tost_pkg::OP_STORE, 32'd5, 32'd600, 32'd2);
		send_op(tost_pkg::OP_STORE, 32'd3, 32'd600, 32'd3);
		send_op(tost_pkg::OP_STORE, 32'd8, 32'd1000, 32'd4);
		drain();
		write_reg(tost_pkg::REG_MAX_TOTAL_BYTES, 32'd0);
		send_op(tost_pkg::OP_STORE, 32'd1, 32'd0, 32'd5);
		send_op(tost_pkg::OP_STORE, 32'd2, 32'd1, 32'd6);
		drain();
		write_reg(tost_pkg::REG_MAX_ENTRIES, 32'd0);
		write_reg(tost_pkg::REG_MAX_TOTAL_BYTES, 32'hFFFF_FFFF);
		send_op(tost_pkg::OP_STORE, 32'd7, 32'd7, 32'd7);
		send_op(tost_pkg::OP_FIND, 32'd7, '0, '0);
		drain();
		// random phases across register settings
		write_reg(tost_pkg::REG_MAX_ENTRIES, 32'd127);
		random_phase(110, 400, 0);
		drain();
		write_reg(tost_pkg::REG_MAX_ENTRIES, 32'd64);
		random_phase(110, 100000, 1);
		drain();
		write_reg(tost_pkg::REG_MAX_ENTRIES, 32'd5);
		write_reg(tost_pkg::REG_MAX_TOTAL_BYTES, 32'd5000);
		random_phase(80, 60, 0);
		drain();
		write_reg(tost_pkg::REG_MAX_ENTRIES, 32'd1);
		write_reg(tost_pkg::REG_MAX_TOTAL_BYTES, 32'h8000_0000);
		random_phase(40, 30, 1);
		drain();
		write_reg(tost_pkg::REG_MAX_ENTRIES, $urandom_range(2, 80));
		write_reg(tost_pkg::REG_MAX_TOTAL_BYTES, $urandom_range(1000, 40000));
		random_phase(110, 200, 0);
		drain();
		if (fail_count == 0)
			$display("tick_ordered_snapshot_table_tb: done, clean");
		else
			$display("tick_ordered_snapshot_table_tb: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
